### hw/rtl/rpe_pkg.sv
// Shared types and constants of the rotation period estimator.
`timescale 1ns / 1ps

package rpe_pkg;

  // Widths of the shared divider: the weighted sum needs 32 + 4 + 1 bits.
  localparam int unsigned DIVIDEND_W = 37;
  localparam int unsigned DIVISOR_W  = 32;
  localparam int unsigned STEP_W     = 6;

  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned RPM_W    = 16;
  localparam int unsigned NUM_W    = 4;
  localparam int unsigned DEN_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // rpm = 60000000 / period; the numerator fits in 26 bits.
  localparam logic [31:0] RPM_NUMERATOR = 32'd60000000;
  localparam int unsigned RPM_BITS      = 26;
  localparam logic [DIVIDEND_W-1:0] RPM_DIVIDEND =
      DIVIDEND_W'(RPM_NUMERATOR) << (DIVIDEND_W - RPM_BITS);
  localparam logic [RPM_W-1:0] RPM_LIMIT = 16'hFFFF;

  localparam logic [STEP_W-1:0] EMA_STEPS = STEP_W'(DIVIDEND_W);
  localparam logic [STEP_W-1:0] RPM_STEPS = STEP_W'(RPM_BITS);

  // Commands
  localparam logic [1:0] CMD_EDGE    = 2'd0;
  localparam logic [1:0] CMD_CHECK   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_SIM     = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PERIOD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EMA_NUMERATOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EMA_DENOMINATOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_TIMEOUT   = 3'd5;

  typedef struct packed {
    logic                  start;
    logic [STEP_W-1:0]     steps;
    logic [DIVIDEND_W-1:0] dividend;  // left-aligned to the step count
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/rotation_period_estimator_core.sv
// Top level of the rotation period estimator: sequencer, state and config.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                 Payload
// in        request    in_valid_i / in_stall_o   cmd_i, now_us_i, sim_value_i
// out       result     out_valid_o / out_stall_i period_out_o, rev_count_out_o,
//                                                rpm_o, sync_flag_o, sim_flag_o,
//                                                loss_event_o
// cfg       write      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One request is in flight at a time; in_stall_o is high from acceptance until
// its result is taken. An edge request that updates the average runs two
// passes through the shared one-bit-per-cycle divider: 37 steps for the
// weighted sum and 26 steps for rpm. Other requests run only the rpm pass,
// and none when the period is zero. Reset clears the sequencer, the tracking
// state and loads the register defaults. The result is held in registers
// while out_stall_i is high, and a stall holds off the next request.

module rotation_period_estimator_core
  import rpe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            cmd_i,
  input  logic [TIME_W-1:0]     now_us_i,
  input  logic                  sim_value_i,
  // Result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PERIOD_W-1:0]   period_out_o,
  output logic [PERIOD_W-1:0]   rev_count_out_o,
  output logic [RPM_W-1:0]      rpm_o,
  output logic                  sync_flag_o,
  output logic                  sim_flag_o,
  output logic                  loss_event_o,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_EMA_LOAD,
    S_EMA_WAIT,
    S_RPM_LOAD,
    S_RPM_WAIT,
    S_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [PERIOD_W-1:0] default_period_q;
  logic [PERIOD_W-1:0] min_period_q;
  logic [PERIOD_W-1:0] max_period_q;
  logic [NUM_W-1:0]    ema_num_q;
  logic [DEN_W-1:0]    ema_den_q;
  logic [PERIOD_W-1:0] loss_timeout_q;

  // Tracking state
  logic [TIME_W-1:0]   last_edge_q;
  logic [PERIOD_W-1:0] period_q;
  logic [PERIOD_W-1:0] revolutions_q;
  logic                synced_q;
  logic                sim_active_q;
  logic                loss_q;
  logic [RPM_W-1:0]    rpm_q;

  // Captured request
  logic [1:0]          cmd_q;
  logic [TIME_W-1:0]   now_q;
  logic                sim_req_q;

  logic [DIVIDEND_W-1:0] sum_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Execute-stage arithmetic
  logic [TIME_W-1:0]   delta;
  logic [PERIOD_W-1:0] sample;
  logic                have_edge;
  logic                in_range;
  logic [DEN_W-1:0]    den_eff;
  logic                ema_needed;
  logic                loss_hit;

  assign delta      = now_q - last_edge_q;
  assign sample     = delta[PERIOD_W-1:0];
  assign have_edge  = (last_edge_q != '0);
  assign in_range   = (sample >= min_period_q) && (sample <= max_period_q);
  assign den_eff    = (ema_den_q == '0) ? DEN_W'(1) : ema_den_q;
  // Average only when an interval is measured, in range, and a period exists.
  assign ema_needed = have_edge && in_range && (period_q != '0);
  // Loss: synced, outside simulation, an edge stored and the gap past timeout.
  assign loss_hit   = synced_q && !sim_active_q && have_edge &&
                      (delta > TIME_W'(loss_timeout_q));

  // Drive the shared divider from the load states only.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.steps    = RPM_STEPS;
    div_req.dividend = RPM_DIVIDEND;
    div_req.divisor  = period_q;
    case (state_q)
      S_EMA_LOAD: begin
        div_req.start    = 1'b1;
        div_req.steps    = EMA_STEPS;
        div_req.dividend = sum_q;
        div_req.divisor  = DIVISOR_W'(den_eff);
      end
      S_RPM_LOAD: begin
        div_req.start = (period_q != '0);
      end
      default: begin
      end
    endcase
  end

  rpe_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_period_q <= '0;
      min_period_q     <= '0;
      max_period_q     <= '1;
      ema_num_q        <= NUM_W'(3);
      ema_den_q        <= DEN_W'(4);
      loss_timeout_q   <= PERIOD_W'(1000000);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEFAULT_PERIOD:  default_period_q <= cfg_data_i;
        REG_MIN_PERIOD:      min_period_q     <= cfg_data_i;
        REG_MAX_PERIOD:      max_period_q     <= cfg_data_i;
        REG_EMA_NUMERATOR:   ema_num_q        <= cfg_data_i[NUM_W-1:0];
        REG_EMA_DENOMINATOR: ema_den_q        <= cfg_data_i[DEN_W-1:0];
        REG_LOSS_TIMEOUT:    loss_timeout_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Sequencer with tracking state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      last_edge_q   <= '0;
      period_q      <= '0;
      revolutions_q <= '0;
      synced_q      <= 1'b0;
      sim_active_q  <= 1'b0;
      loss_q        <= 1'b0;
      rpm_q         <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          loss_q  <= (cmd_q == CMD_CHECK) && loss_hit;
          state_q <= ((cmd_q == CMD_EDGE) && ema_needed) ? S_EMA_LOAD : S_RPM_LOAD;
          case (cmd_q)
            CMD_EDGE: begin
              // Load the interval directly when no period is held yet.
              if (have_edge && in_range && (period_q == '0)) begin
                period_q <= sample;
              end
              last_edge_q   <= now_q;
              revolutions_q <= revolutions_q + PERIOD_W'(1);
              synced_q      <= 1'b1;
            end
            CMD_CHECK: begin
              // Drop sync when the gap since the last edge runs past the timeout.
              if (loss_hit) begin
                synced_q <= 1'b0;
              end
            end
            CMD_RESTART: begin
              last_edge_q <= '0;
              period_q    <= default_period_q;
              synced_q    <= 1'b0;
            end
            CMD_SIM: begin
              sim_active_q <= sim_req_q;
              synced_q     <= 1'b0;
              last_edge_q  <= '0;
              if (sim_req_q) begin
                period_q <= default_period_q;
              end
            end
            default: begin
            end
          endcase
        end
        S_EMA_LOAD: begin
          state_q <= S_EMA_WAIT;
        end
        S_EMA_WAIT: begin
          if (div_rsp.done) begin
            // Saturate an average that no longer fits in 32 bits.
            if (|div_rsp.quotient[DIVIDEND_W-1:PERIOD_W]) begin
              period_q <= '1;
            end else begin
              period_q <= div_rsp.quotient[PERIOD_W-1:0];
            end
            state_q <= S_RPM_LOAD;
          end
        end
        S_RPM_LOAD: begin
          if (period_q == '0) begin
            rpm_q   <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_RPM_WAIT;
          end
        end
        S_RPM_WAIT: begin
          if (div_rsp.done) begin
            if (|div_rsp.quotient[DIVIDEND_W-1:RPM_W]) begin
              rpm_q <= RPM_LIMIT;
            end else begin
              rpm_q <= div_rsp.quotient[RPM_W-1:0];
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Capture the request payload and the weighted sum.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q     <= cmd_i;
      now_q     <= now_us_i;
      sim_req_q <= sim_value_i;
    end
    if (state_q == S_EXEC) begin
      sum_q <= DIVIDEND_W'(period_q) * DIVIDEND_W'(ema_num_q) + DIVIDEND_W'(sample);
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = (state_q == S_OUT);
  assign period_out_o    = period_q;
  assign rev_count_out_o = revolutions_q;
  assign rpm_o           = rpm_q;
  assign sync_flag_o     = synced_q | sim_active_q;
  assign sim_flag_o      = sim_active_q;
  assign loss_event_o    = loss_q;

  // A pending result blocks new requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request accepted while a result is pending");

  // A detected loss leaves the block unsynced and outside simulation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && loss_event_o) |-> !sync_flag_o)
    else $error("loss reported while still synced");

  // A zero period always reads as zero rpm.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && period_out_o == '0) |-> (rpm_o == '0))
    else $error("nonzero rpm for a zero period");

  // The divider finishes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_EMA_WAIT || state_q == S_RPM_WAIT))
    else $error("divider finished outside a wait state");

endmodule

### hw/rtl/rpe_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rpe_divider
  import rpe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_W-1:0]     count_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  divisor_q;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign ge    = (trial >= {1'b0, divisor_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      count_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        count_q <= req_i.steps;
      end else if (busy_q) begin
        count_q <= count_q - STEP_W'(1);
        if (count_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit, subtract when it fits.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= '0;
      quo_q     <= req_i.dividend;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
